// ----- rtl/lli_pkg.sv -----
// Shared types, constants and helpers for the line pair crossing unit.
// Used by every module under rtl and by the port checker; depends on nothing.
package lli_pkg;

   localparam int COORD_W = 48;
   localparam int SLOPE_W = 32;
   localparam int TOL_W = 20;
   localparam int SLOPE_FRAC_BITS_DEF = 30;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   localparam logic [1:0] STATUS_CROSS = 2'd0;
   localparam logic [1:0] STATUS_PARALLEL = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope_a;
      logic signed [COORD_W-1:0] intercept_a;
      logic inverted_a;
      logic signed [SLOPE_W-1:0] slope_b;
      logic signed [COORD_W-1:0] intercept_b;
      logic inverted_b;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cross_x;
      logic signed [COORD_W-1:0] cross_y;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      req_type pair;
      logic mixed;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0] quo;
      logic big;
      logic neg;
   } div_res_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic sat;
   } sat_type;

   function automatic sat_type saturate(input div_res_type r);
      sat_type s;
      s.value = COORD_MAX;
      s.sat = 1'b0;
      if (r.neg) begin
         if (r.big || (r.quo[COORD_W-1] && (|r.quo[COORD_W-2:0]))) begin
            s.value = COORD_MIN;
            s.sat = 1'b1;
         end else begin
            s.value = $signed(COORD_W'(~r.quo + 1'b1));
         end
      end else begin
         if (r.big || r.quo[COORD_W-1]) begin
            s.value = COORD_MAX;
            s.sat = 1'b1;
         end else begin
            s.value = $signed(r.quo);
         end
      end
      return s;
   endfunction

endpackage

// ----- rtl/line_line_intersection.sv -----
// Line pair crossing unit, top level: tolerance register, input stage, queue, pipeline.
// Depends on lli_pkg, lli_front, lli_queue and lli_back.
//
// Each transfer on the req_ channel carries two lines, each a slope, an intercept and
// an inverted flag. Each transfer on the rsp_ channel carries the crossing point and a
// status: crossing found, parallel, or crossing saturated to the coordinate range.
// Both channels use valid and stall; a transfer happens on a clock edge where valid is
// high and stall is low. The csr_ port writes the parallel tolerance (in slope LSBs);
// write it only while no item is in flight.
// One pair is accepted per cycle while req_stall is low. Each request passes through one
// input stage, one queue slot, four arithmetic stages, 49 divider stages (a load stage,
// then one quotient bit each) and the output register before its result appears.
// While a valid result meets a high rsp_stall, it holds and the pipeline freezes; the
// four-entry queue and input stage keep accepting until full, then req_stall rises.
// Synchronous reset empties the pipeline and queue and sets the tolerance to one.
module line_line_intersection #(
   parameter int SLOPE_FRAC_BITS = lli_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  lli_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output lli_pkg::rsp_type rsp_data,
   input  logic csr_write_en,
   input  logic [lli_pkg::TOL_W-1:0] csr_write_data
);
   import lli_pkg::*;

   logic [TOL_W-1:0] tol_ff;
   logic q_full;
   logic push_valid;
   item_type push_item;
   logic pop;
   logic head_valid;
   item_type head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   lli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   lli_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   lli_back #(.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .tolerance  (tol_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/lli_front.sv -----
// Input stage of the line pair crossing unit: registers each pair and classifies it.
// Depends on lli_pkg.
module lli_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  lli_pkg::req_type req_data,
   input  logic q_full,
   output logic push_valid,
   output lli_pkg::item_type push_item
);
   import lli_pkg::*;

   logic valid_ff;
   item_type item_ff;
   item_type item_in;
   logic front_en;

   assign front_en = !valid_ff || !q_full;
   assign req_stall = !front_en;

   always_comb begin
      item_in.pair = req_data;
      item_in.mixed = req_data.inverted_a ^ req_data.inverted_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (front_en) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en && req_valid) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff && !q_full;
   assign push_item = item_ff;

endmodule

// ----- rtl/lli_queue.sv -----
// Short queue that decouples the input stage from the arithmetic pipeline.
// Depends on lli_pkg.
module lli_queue #(
   parameter int DEPTH = lli_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  lli_pkg::item_type push_item,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output lli_pkg::item_type head_item
);
   import lli_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/lli_div.sv -----
// Pipelined restoring divider that yields one quotient bit per stage plus an overflow flag.
// Depends on lli_pkg.
module lli_div #(
   parameter int DEN_W = 2 * lli_pkg::SLOPE_FRAC_BITS_DEF + 34
) (
   input  logic clock,
   input  logic enable,
   input  logic [DEN_W+lli_pkg::COORD_W-1:0] num_mag,
   input  logic [DEN_W-1:0] den_mag,
   input  logic neg,
   output lli_pkg::div_res_type res
);
   import lli_pkg::*;

   localparam int NUM_W = DEN_W + COORD_W;
   localparam int STAGES = COORD_W;

   logic [DEN_W-1:0] rem_ff [0:STAGES];
   logic [DEN_W-1:0] den_ff [0:STAGES];
   logic [COORD_W-1:0] low_ff [0:STAGES];
   logic [COORD_W-1:0] quo_ff [0:STAGES];
   logic big_ff [0:STAGES];
   logic neg_ff [0:STAGES];
   logic big_in;

   // The quotient fits in the output word only when the numerator is below den * 2^48.
   assign big_in = (num_mag >= {den_mag, {COORD_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_mag[NUM_W-1:COORD_W];
         den_ff[0] <= den_mag;
         low_ff[0] <= num_mag[COORD_W-1:0];
         quo_ff[0] <= '0;
         big_ff[0] <= big_in;
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 1; k <= STAGES; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic ge;

      assign trial = {rem_ff[k-1], low_ff[k-1][COORD_W-1]};
      assign diff = trial - {1'b0, den_ff[k-1]};
      assign ge = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= {low_ff[k-1][COORD_W-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][COORD_W-2:0], ge};
            big_ff[k] <= big_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   always_comb begin
      res.quo = quo_ff[STAGES];
      res.big = big_ff[STAGES];
      res.neg = neg_ff[STAGES];
   end

endmodule

// ----- rtl/lli_back.sv -----
// Arithmetic pipeline: products, parallel test, numerators, two dividers and saturation.
// Depends on lli_pkg and lli_div.
module lli_back #(
   parameter int SLOPE_FRAC_BITS = lli_pkg::SLOPE_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [lli_pkg::TOL_W-1:0] tolerance,
   input  logic head_valid,
   input  lli_pkg::item_type head_item,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output lli_pkg::rsp_type rsp_data
);
   import lli_pkg::*;

   localparam int S = SLOPE_FRAC_BITS;
   localparam int DEN_W = 2 * S + 34;
   localparam int NUM_W = DEN_W + COORD_W;
   localparam int PROD_W = SLOPE_W + COORD_W;
   localparam int HALF = COORD_W / 2;
   localparam int MM_W = 2 * SLOPE_W;
   localparam int LIM_W = TOL_W + SLOPE_W;
   localparam int DIV_STAGES = COORD_W + 1;
   localparam logic signed [DEN_W-1:0] UNITY = DEN_W'(1) << (2 * S);

   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   // Stage 1: partial products and differences.
   logic signed [SLOPE_W-1:0] ma, mb;
   logic signed [COORD_W-1:0] ia, ib;
   logic [SLOPE_W-1:0] mb_mag;
   logic signed [SLOPE_W+HALF-1:0] ab_hi_in, ba_hi_in;
   logic signed [SLOPE_W+HALF:0] ab_lo_in, ba_lo_in;
   logic signed [MM_W-1:0] mm_in;
   logic [LIM_W-1:0] lim_in;
   logic signed [SLOPE_W:0] dl_in;
   logic signed [COORD_W:0] nd_in;

   logic s1_valid_ff;
   logic signed [SLOPE_W+HALF-1:0] s1_ab_hi_ff, s1_ba_hi_ff;
   logic signed [SLOPE_W+HALF:0] s1_ab_lo_ff, s1_ba_lo_ff;
   logic signed [MM_W-1:0] s1_mm_ff;
   logic [LIM_W-1:0] s1_lim_ff;
   logic signed [SLOPE_W:0] s1_dl_ff;
   logic signed [COORD_W:0] s1_nd_ff;
   logic signed [COORD_W-1:0] s1_ia_ff, s1_ib_ff;
   logic s1_mbz_ff, s1_mixed_ff, s1_inva_ff;

   always_comb begin
      ma = head_item.pair.slope_a;
      mb = head_item.pair.slope_b;
      ia = head_item.pair.intercept_a;
      ib = head_item.pair.intercept_b;
      mb_mag = mb[SLOPE_W-1] ? (~mb + 1'b1) : mb;
      ab_hi_in = ma * $signed(ib[COORD_W-1:HALF]);
      ab_lo_in = ma * $signed({1'b0, ib[HALF-1:0]});
      ba_hi_in = mb * $signed(ia[COORD_W-1:HALF]);
      ba_lo_in = mb * $signed({1'b0, ia[HALF-1:0]});
      mm_in = ma * mb;
      lim_in = tolerance * mb_mag;
      dl_in = ma - mb;
      nd_in = ib - ia;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ab_hi_ff <= ab_hi_in;
         s1_ab_lo_ff <= ab_lo_in;
         s1_ba_hi_ff <= ba_hi_in;
         s1_ba_lo_ff <= ba_lo_in;
         s1_mm_ff <= mm_in;
         s1_lim_ff <= lim_in;
         s1_dl_ff <= dl_in;
         s1_nd_ff <= nd_in;
         s1_ia_ff <= ia;
         s1_ib_ff <= ib;
         s1_mbz_ff <= (mb == '0);
         s1_mixed_ff <= head_item.mixed;
         s1_inva_ff <= head_item.pair.inverted_a;
      end
   end

   // Stage 2: full products and the like-orientation parallel test.
   logic signed [PROD_W-1:0] pab_in, pba_in;
   logic signed [DEN_W-1:0] mixdiff_in;
   logic [SLOPE_W:0] dl_mag;
   logic parlike_in;

   logic s2_valid_ff;
   logic signed [PROD_W-1:0] s2_pab_ff, s2_pba_ff;
   logic signed [DEN_W-1:0] s2_mixdiff_ff;
   logic [LIM_W-1:0] s2_lim_ff;
   logic s2_parlike_ff;
   logic signed [SLOPE_W:0] s2_dl_ff;
   logic signed [COORD_W:0] s2_nd_ff;
   logic signed [COORD_W-1:0] s2_ia_ff, s2_ib_ff;
   logic s2_mbz_ff, s2_mixed_ff, s2_inva_ff;

   always_comb begin
      pab_in = (PROD_W'(s1_ab_hi_ff) <<< HALF) + PROD_W'(s1_ab_lo_ff);
      pba_in = (PROD_W'(s1_ba_hi_ff) <<< HALF) + PROD_W'(s1_ba_lo_ff);
      mixdiff_in = DEN_W'(s1_mm_ff) - UNITY;
      dl_mag = s1_dl_ff[SLOPE_W] ? (~s1_dl_ff + 1'b1) : s1_dl_ff;
      parlike_in = (dl_mag <= (SLOPE_W + 1)'(tolerance));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pab_ff <= pab_in;
         s2_pba_ff <= pba_in;
         s2_mixdiff_ff <= mixdiff_in;
         s2_lim_ff <= s1_lim_ff;
         s2_parlike_ff <= parlike_in;
         s2_dl_ff <= s1_dl_ff;
         s2_nd_ff <= s1_nd_ff;
         s2_ia_ff <= s1_ia_ff;
         s2_ib_ff <= s1_ib_ff;
         s2_mbz_ff <= s1_mbz_ff;
         s2_mixed_ff <= s1_mixed_ff;
         s2_inva_ff <= s1_inva_ff;
      end
   end

   // Stage 3: parallel decision, numerators and divisor.
   logic [DEN_W-1:0] mix_mag;
   logic par_in;
   logic signed [NUM_W-1:0] nd_sh, nc, na, nb;
   logic signed [NUM_W-1:0] numx_in, numy_in;
   logic signed [DEN_W-1:0] den_in;

   logic s3_valid_ff, s3_par_ff;
   logic signed [NUM_W-1:0] s3_numx_ff, s3_numy_ff;
   logic signed [DEN_W-1:0] s3_den_ff;

   always_comb begin
      mix_mag = s2_mixdiff_ff[DEN_W-1] ? (~s2_mixdiff_ff + 1'b1) : s2_mixdiff_ff;
      par_in = s2_mixed_ff ? (!s2_mbz_ff && (DEN_W'(s2_lim_ff) >= mix_mag)) : s2_parlike_ff;
      nd_sh = NUM_W'(s2_nd_ff) <<< S;
      nc = NUM_W'(s2_pab_ff) - NUM_W'(s2_pba_ff);
      na = (NUM_W'(s2_pab_ff) + (NUM_W'(s2_ia_ff) <<< S)) <<< S;
      nb = (NUM_W'(s2_pba_ff) + (NUM_W'(s2_ib_ff) <<< S)) <<< S;
      if (s2_mixed_ff) begin
         den_in = -s2_mixdiff_ff;
         numx_in = s2_inva_ff ? na : nb;
         numy_in = s2_inva_ff ? nb : na;
      end else begin
         den_in = DEN_W'(s2_dl_ff);
         numx_in = s2_inva_ff ? nc : nd_sh;
         numy_in = s2_inva_ff ? nd_sh : nc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_par_ff <= par_in;
         s3_numx_ff <= numx_in;
         s3_numy_ff <= numy_in;
         s3_den_ff <= den_in;
      end
   end

   // Stage 4: magnitudes and quotient signs.
   logic s4_valid_ff, s4_par_ff;
   logic [NUM_W-1:0] s4_nx_ff, s4_ny_ff;
   logic [DEN_W-1:0] s4_d_ff;
   logic s4_negx_ff, s4_negy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_par_ff <= s3_par_ff;
         s4_nx_ff <= s3_numx_ff[NUM_W-1] ? (~s3_numx_ff + 1'b1) : s3_numx_ff;
         s4_ny_ff <= s3_numy_ff[NUM_W-1] ? (~s3_numy_ff + 1'b1) : s3_numy_ff;
         s4_d_ff <= s3_den_ff[DEN_W-1] ? (~s3_den_ff + 1'b1) : s3_den_ff;
         s4_negx_ff <= s3_numx_ff[NUM_W-1] ^ s3_den_ff[DEN_W-1];
         s4_negy_ff <= s3_numy_ff[NUM_W-1] ^ s3_den_ff[DEN_W-1];
      end
   end

   // Dividers, with the valid and parallel flags running alongside.
   div_res_type res_x, res_y;
   logic pv_valid_ff [0:DIV_STAGES-1];
   logic pv_par_ff [0:DIV_STAGES-1];

   lli_div #(.DEN_W(DEN_W)) u_div_x (
      .clock   (clock),
      .enable  (adv),
      .num_mag (s4_nx_ff),
      .den_mag (s4_d_ff),
      .neg     (s4_negx_ff),
      .res     (res_x)
   );

   lli_div #(.DEN_W(DEN_W)) u_div_y (
      .clock   (clock),
      .enable  (adv),
      .num_mag (s4_ny_ff),
      .den_mag (s4_d_ff),
      .neg     (s4_negy_ff),
      .res     (res_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            pv_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         pv_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            pv_valid_ff[i] <= pv_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pv_par_ff[0] <= s4_par_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            pv_par_ff[i] <= pv_par_ff[i-1];
         end
      end
   end

   // Saturation and the output register.
   sat_type sx, sy;
   rsp_type rsp_in;

   always_comb begin
      sx = saturate(res_x);
      sy = saturate(res_y);
      if (pv_par_ff[DIV_STAGES-1]) begin
         rsp_in.cross_x = '0;
         rsp_in.cross_y = '0;
         rsp_in.status = STATUS_PARALLEL;
      end else begin
         rsp_in.cross_x = sx.value;
         rsp_in.cross_y = sy.value;
         rsp_in.status = (sx.sat || sy.sat) ? STATUS_SAT : STATUS_CROSS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pv_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- rtl/lli_checker.sv -----
// Port-level checks on the result channel of the line pair crossing unit, and their bind.
// Depends on lli_pkg and line_line_intersection.
module lli_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input lli_pkg::rsp_type rsp_data
);
   import lli_pkg::*;

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_PARALLEL) |->
         (rsp_data.cross_x == '0) && (rsp_data.cross_y == '0))
      else $error("parallel result with nonzero coordinates");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_SAT) |->
         (rsp_data.cross_x == COORD_MAX) || (rsp_data.cross_x == COORD_MIN) ||
         (rsp_data.cross_y == COORD_MAX) || (rsp_data.cross_y == COORD_MIN))
      else $error("saturated result without a coordinate at a bound");

endmodule

bind line_line_intersection lli_checker u_lli_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
